// File: design/markup_head_section_extractor_unit_macros.svh
// assertion macros for the markup head section extractor
// used by the scanner and the result queue, needs clk and rst_n in scope
`ifndef MARKUP_HEAD_SECTION_EXTRACTOR_UNIT_MACROS_SVH
`define MARKUP_HEAD_SECTION_EXTRACTOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MHSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// plain invariant, disabled during reset
`define MHSE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> (cond)) \
    else $error(msg);

`endif

// File: design/mhse_pkg.sv
// shared types, byte constants and helpers of the head section extractor
// no dependencies
package mhse_pkg;

  localparam int HOLD_DEPTH = 5;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // "<head" and "</head", lower case
  localparam logic [7:0] OPEN_PAT [5] = '{8'h3C, 8'h68, 8'h65, 8'h61, 8'h64};
  localparam logic [7:0] CLOSE_PAT [6] = '{8'h3C, 8'h2F, 8'h68, 8'h65, 8'h61, 8'h64};

  // results caused by one byte: held prefix, then the byte itself, then the verdict
  typedef struct packed {
    logic [HOLD_DEPTH-1:0][7:0] held;
    logic [7:0]                 cur;
    logic [2:0]                 n_held;
    logic                       cur_en;
    logic                       verdict_en;
    logic                       verdict_val;
  } res_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

// File: design/mhse_if.sv
// valid/ready channel interfaces for source bytes and result words
// no dependencies
interface mhse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_source;
  modport source (output valid, in_byte, end_of_source, input ready);
  modport sink (input valid, in_byte, end_of_source, output ready);
endinterface

interface mhse_out_if;
  logic       valid;
  logic       ready;
  logic       has_content_byte;
  logic [7:0] content_byte;
  logic       verdict_valid;
  logic       head_present;
  logic       run_last;
  modport source (output valid, has_content_byte, content_byte, verdict_valid,
                  head_present, run_last, input ready);
  modport sink (input valid, has_content_byte, content_byte, verdict_valid,
                head_present, run_last, output ready);
endinterface

// File: design/mhse_scan.sv
// per-byte scanner: open tag match, quote tracking, close tag hold buffer
// depends on mhse_pkg and the macros header
`include "markup_head_section_extractor_unit_macros.svh"
module mhse_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            end_of_source,
  output mhse_pkg::res_t  res,
  output logic            res_any
);
  import mhse_pkg::*;

  typedef enum logic [1:0] {PH_SEEK, PH_TAG, PH_CONTENT, PH_DONE} phase_t;
  typedef enum logic [1:0] {Q_NONE, Q_SINGLE, Q_DOUBLE} quote_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] omc_r, omc_nxt;
  quote_t     quote_r, quote_nxt;
  logic       slash_r, slash_nxt;
  logic [2:0] cc_r, cc_nxt;
  logic [7:0] held_r [HOLD_DEPTH];

  logic       hw_en;
  logic [2:0] hw_idx;
  logic       tag_act;
  quote_t     tq;
  logic       ts;
  logic       upd;
  logic [7:0] lc;
  logic       is_lt;

  always_comb begin
    phase_nxt = phase_r;
    omc_nxt   = omc_r;
    quote_nxt = quote_r;
    slash_nxt = slash_r;
    cc_nxt    = cc_r;
    hw_en     = 1'b0;
    hw_idx    = cc_r;
    tag_act   = 1'b0;
    tq        = quote_r;
    ts        = slash_r;
    upd       = 1'b1;
    lc        = fold_case(in_byte);
    is_lt     = (in_byte == CH_LT);
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      res.held[k] = held_r[k];
    end
    res.cur         = in_byte;
    res.n_held      = 3'd0;
    res.cur_en      = 1'b0;
    res.verdict_en  = 1'b0;
    res.verdict_val = 1'b0;

    case (phase_r)
      PH_SEEK: begin
        if (omc_r >= 3'd5) begin
          if (in_byte == CH_GT || in_byte == CH_SLASH || is_space(in_byte)) begin
            phase_nxt = PH_TAG;
            omc_nxt   = 3'd0;
            tag_act   = 1'b1;
            tq        = Q_NONE;
            ts        = 1'b0;
          end else begin
            omc_nxt = {2'b00, is_lt};
          end
        end else if (lc == OPEN_PAT[omc_r]) begin
          omc_nxt = omc_r + 3'd1;
        end else begin
          omc_nxt = {2'b00, is_lt};
        end
      end
      PH_TAG: begin
        tag_act = 1'b1;
      end
      PH_CONTENT: begin
        if (lc == CLOSE_PAT[cc_r]) begin
          if (cc_r == 3'd5) begin
            cc_nxt          = 3'd0;
            res.verdict_en  = 1'b1;
            res.verdict_val = 1'b1;
            phase_nxt       = PH_DONE;
          end else begin
            hw_en  = 1'b1;
            hw_idx = cc_r;
            cc_nxt = cc_r + 3'd1;
          end
        end else begin
          res.n_held = cc_r;
          cc_nxt     = 3'd0;
          if (is_lt) begin
            hw_en  = 1'b1;
            hw_idx = 3'd0;
            cc_nxt = 3'd1;
          end else begin
            res.cur_en = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (tag_act) begin
      quote_nxt = tq;
      slash_nxt = ts;
      if (tq == Q_SINGLE) begin
        if (in_byte == CH_SQ) quote_nxt = Q_NONE;
      end else if (tq == Q_DOUBLE) begin
        if (in_byte == CH_DQ) quote_nxt = Q_NONE;
      end else if (in_byte == CH_SQ) begin
        quote_nxt = Q_SINGLE;
      end else if (in_byte == CH_DQ) begin
        quote_nxt = Q_DOUBLE;
      end else if (in_byte == CH_GT) begin
        upd = 1'b0;
        if (ts) begin
          res.verdict_en  = 1'b1;
          res.verdict_val = 1'b1;
          phase_nxt       = PH_DONE;
        end else begin
          phase_nxt = PH_CONTENT;
          cc_nxt    = 3'd0;
        end
      end
      if (upd && !is_space(in_byte)) slash_nxt = (in_byte == CH_SLASH);
    end

    if (end_of_source) begin
      // flush whatever is held, this byte last
      if (phase_nxt == PH_CONTENT && phase_r == PH_CONTENT) begin
        res.n_held = cc_r;
        res.cur_en = 1'b1;
      end
      if (phase_nxt != PH_DONE) begin
        res.verdict_en  = 1'b1;
        res.verdict_val = (phase_nxt == PH_CONTENT);
      end
      phase_nxt = PH_SEEK;
      omc_nxt   = 3'd0;
      quote_nxt = Q_NONE;
      slash_nxt = 1'b0;
      cc_nxt    = 3'd0;
    end

    res_any = (res.n_held != 3'd0) || res.cur_en || res.verdict_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      omc_r   <= 3'd0;
      quote_r <= Q_NONE;
      slash_r <= 1'b0;
      cc_r    <= 3'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      omc_r   <= omc_nxt;
      quote_r <= quote_nxt;
      slash_r <= slash_nxt;
      cc_r    <= cc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hw_en) held_r[hw_idx] <= in_byte;
  end

  `MHSE_ASSERT_ALWAYS(a_omc_range, omc_r <= 3'd5, "open match count out of range")
  `MHSE_ASSERT_NOW(a_omc_seek, phase_r != PH_SEEK, omc_r == 3'd0, "open match outside seek")
  `MHSE_ASSERT_NOW(a_cc_content, cc_r != 3'd0, phase_r == PH_CONTENT && cc_r <= 3'd5,
                   "close match outside content")

endmodule

// File: design/mhse_result_q.sv
// result register that drains one byte's results one word per cycle while out_ready is high
// depends on mhse_pkg and the macros header
`include "markup_head_section_extractor_unit_macros.svh"
module mhse_result_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  mhse_pkg::res_t  res,
  input  logic            out_ready,
  output logic            out_valid,
  output logic            has_content_byte,
  output logic [7:0]      content_byte,
  output logic            verdict_valid,
  output logic            head_present,
  output logic            run_last
);
  import mhse_pkg::*;

  logic [HOLD_DEPTH-1:0][7:0] held_r;
  logic [7:0] cur_r;
  logic [2:0] nh_r;
  logic [2:0] ptr_r;
  logic       c_pend_r;
  logic       v_pend_r;
  logic       v_val_r;

  logic       in_held;
  logic [2:0] ptr_idx;
  logic [3:0] rem;
  logic       fire;

  always_comb begin
    in_held   = (ptr_r < nh_r);
    ptr_idx   = (ptr_r < 3'(HOLD_DEPTH)) ? ptr_r : 3'd0;
    out_valid = in_held || c_pend_r || v_pend_r;
    rem       = 4'(nh_r) - 4'(ptr_r) + 4'(c_pend_r) + 4'(v_pend_r);
    run_last  = (rem == 4'd1);
    fire      = out_valid && out_ready;
    has_content_byte = in_held || c_pend_r;
    content_byte     = in_held ? held_r[ptr_idx] : (c_pend_r ? cur_r : 8'd0);
    verdict_valid    = !in_held && !c_pend_r && v_pend_r;
    head_present     = verdict_valid && v_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nh_r     <= 3'd0;
      ptr_r    <= 3'd0;
      c_pend_r <= 1'b0;
      v_pend_r <= 1'b0;
    end else if (load) begin
      nh_r     <= res.n_held;
      ptr_r    <= 3'd0;
      c_pend_r <= res.cur_en;
      v_pend_r <= res.verdict_en;
    end else if (fire) begin
      if (in_held) ptr_r <= ptr_r + 3'd1;
      else if (c_pend_r) c_pend_r <= 1'b0;
      else v_pend_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      held_r  <= res.held;
      cur_r   <= res.cur;
      v_val_r <= res.verdict_val;
    end
  end

  `MHSE_ASSERT_ALWAYS(a_ptr_bound, ptr_r <= nh_r, "held pointer past held count")
  `MHSE_ASSERT_ALWAYS(a_nh_bound, nh_r <= 3'(HOLD_DEPTH), "held count beyond hold depth")
  `MHSE_ASSERT_NOW(a_one_kind, out_valid, has_content_byte ^ verdict_valid,
                   "result word carries both or neither kind")

endmodule

// File: design/markup_head_section_extractor_unit.sv
// output: the first result word of a byte is offered in the cycle after the byte is taken
// throughput: one byte per cycle while out_ch.ready is high and each byte causes at most
//   one result word; a byte causing k words (at most 7) holds the result register until
//   they leave, one per ready cycle, and the next byte is taken with the last word
// reset: synchronous active-low rst_n returns the scanner to seeking "<head" and
//   empties the result register; the close-tag hold buffer has no reset
module markup_head_section_extractor_unit (
  input  logic  clk,
  input  logic  rst_n,
  mhse_in_if.sink    in_ch,
  mhse_out_if.source out_ch
);
  import mhse_pkg::*;

  res_t res;
  logic res_any;
  logic out_valid;
  logic run_last;
  logic in_ready;
  logic in_fire;

  // take a byte when the result register is empty or its last word leaves now
  assign in_ready    = !out_valid || (run_last && out_ch.ready);
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  // scanner: state updates on each taken byte, results built combinationally
  mhse_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_fire),
    .in_byte       (in_ch.in_byte),
    .end_of_source (in_ch.end_of_source),
    .res           (res),
    .res_any       (res_any)
  );

  // result register: held prefix, then the byte, then the verdict
  mhse_result_q u_result_q (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (in_fire && res_any),
    .res              (res),
    .out_ready        (out_ch.ready),
    .out_valid        (out_valid),
    .has_content_byte (out_ch.has_content_byte),
    .content_byte     (out_ch.content_byte),
    .verdict_valid    (out_ch.verdict_valid),
    .head_present     (out_ch.head_present),
    .run_last         (run_last)
  );

  assign out_ch.valid    = out_valid;
  assign out_ch.run_last = run_last;

endmodule
